[sv/smvp_pkg.sv]
// smvp_pkg: shared types, item codes and default sizes for the sharded
// matrix-vector product unit. No dependencies; used by every module in sv/.
package smvp_pkg;

    localparam int ROWS_DEF       = 64;
    localparam int COLS_DEF       = 64;
    localparam int SHARDS_DEF     = 4;
    localparam int PLAIN_BITS_DEF = 8;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_we;
        logic mat_we;
        logic q_start;
        logic sw_issue;
        logic rd_issue;
        logic rd_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic idx_last;
        logic pipe_busy;
        logic out_full;
    } t_stat;

    function automatic int addr_width(input int n);
        addr_width = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[sv/smvp_ctrl.sv]
// smvp_ctrl: state machine sequencing the clear pass, query sweeps and reads.
// Depends on smvp_pkg (t_state, t_cmd, t_stat, item codes).
module smvp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_kind,
    input  smvp_pkg::t_stat  i_stat,
    output logic             o_stall,
    output smvp_pkg::t_cmd   o_cmd
);

    smvp_pkg::t_state r_state;
    smvp_pkg::t_state n_state;
    logic             w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smvp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_stall  = 1'b1;
        w_accept = 1'b0;
        unique case (r_state)
            smvp_pkg::ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = smvp_pkg::ST_IDLE;
                end
            end
            smvp_pkg::ST_IDLE: begin
                // a read needs the output register free
                o_stall  = (i_kind == smvp_pkg::KIND_READ) && i_stat.out_full;
                w_accept = i_valid && !o_stall;
                if (w_accept) begin
                    priority if (i_kind == smvp_pkg::KIND_WRITE) begin
                        o_cmd.mat_we = 1'b1;
                    end else if (i_kind == smvp_pkg::KIND_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_state       = smvp_pkg::ST_SWEEP;
                    end else if (i_kind == smvp_pkg::KIND_READ) begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = smvp_pkg::ST_READ;
                    end else begin
                        n_state = smvp_pkg::ST_IDLE;
                    end
                end
            end
            smvp_pkg::ST_SWEEP: begin
                o_cmd.sw_issue = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = smvp_pkg::ST_DRAIN;
                end
            end
            smvp_pkg::ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = smvp_pkg::ST_IDLE;
                end
            end
            smvp_pkg::ST_READ: begin
                o_cmd.rd_load = 1'b1;
                n_state       = smvp_pkg::ST_IDLE;
            end
            default: begin
                n_state = smvp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/smvp_dpath.sv]
// smvp_dpath: matrix and accumulator memories, multiply-accumulate pipeline
// and output register. Depends on smvp_pkg (t_cmd, t_stat, addr_width).
module smvp_dpath #(
    parameter int ROWS       = smvp_pkg::ROWS_DEF,
    parameter int COLS       = smvp_pkg::COLS_DEF,
    parameter int SHARDS     = smvp_pkg::SHARDS_DEF,
    parameter int PLAIN_BITS = smvp_pkg::PLAIN_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smvp_pkg::t_cmd   i_cmd,
    input  logic [1:0]       i_shard_sel,
    input  logic [5:0]       i_row_sel,
    input  logic [5:0]       i_col_sel,
    input  logic [7:0]       i_entry_value,
    input  logic [31:0]      i_query_value,
    input  logic             i_first_element,
    input  logic             i_stall,
    output smvp_pkg::t_stat  o_stat,
    output logic             o_valid,
    output logic [31:0]      o_product_word
);

    localparam int ACC_N  = SHARDS * ROWS;
    localparam int MAT_N  = SHARDS * ROWS * COLS;
    localparam int ACC_AW = smvp_pkg::addr_width(ACC_N);
    localparam int MAT_AW = smvp_pkg::addr_width(MAT_N);

    logic [PLAIN_BITS-1:0] r_mat [MAT_N];
    logic [31:0]           r_acc [ACC_N];

    logic [ACC_AW-1:0]     r_idx;
    logic [MAT_AW-1:0]     r_mbase;
    logic [31:0]           r_qval;
    logic                  r_first;
    logic                  r_col_ok;

    logic                  r_v1;
    logic                  r_v2;
    logic [ACC_AW-1:0]     r_wa1;
    logic [ACC_AW-1:0]     r_wa2;
    logic [PLAIN_BITS-1:0] r_mat_rd;
    logic [31:0]           r_acc_rd;
    logic [31:0]           r_acc_old;
    logic [31:0]           r_prod;

    logic                  r_rd_ok;
    logic                  r_out_valid;
    logic [31:0]           r_out_word;

    logic                  w_shard_ok;
    logic                  w_row_ok;
    logic                  w_col_ok;
    logic [31:0]           w_acc_addr;
    logic [31:0]           w_mat_addr;
    logic [31:0]           w_entry32;
    logic [31:0]           w_prod;
    logic [31:0]           w_acc_wd;
    logic                  w_acc_we;
    logic [ACC_AW-1:0]     w_acc_wa;
    logic                  w_acc_re;
    logic [ACC_AW-1:0]     w_acc_ra;

    assign w_shard_ok = 32'(i_shard_sel) < 32'(SHARDS);
    assign w_row_ok   = 32'(i_row_sel) < 32'(ROWS);
    assign w_col_ok   = 32'(i_col_sel) < 32'(COLS);
    assign w_acc_addr = 32'(i_shard_sel) * 32'(ROWS) + 32'(i_row_sel);
    assign w_mat_addr = w_acc_addr * 32'(COLS) + 32'(i_col_sel);
    assign w_entry32  = 32'(i_entry_value);

    // matrix store: one write port, one registered read port for the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_we && w_shard_ok && w_row_ok && w_col_ok) begin
            r_mat[w_mat_addr[MAT_AW-1:0]] <= w_entry32[PLAIN_BITS-1:0];
        end
        if (i_cmd.sw_issue) begin
            r_mat_rd <= r_mat[r_mbase];
        end
    end

    // accumulator ports: clear pass or pipeline write; sweep or result read
    assign w_acc_we = i_cmd.clr_we || r_v2;
    assign w_acc_wa = i_cmd.clr_we ? r_idx : r_wa2;
    assign w_acc_wd = i_cmd.clr_we ? 32'd0 : (r_first ? r_prod : r_acc_old + r_prod);
    assign w_acc_re = i_cmd.sw_issue || i_cmd.rd_issue;
    assign w_acc_ra = i_cmd.sw_issue ? r_idx : w_acc_addr[ACC_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc[w_acc_wa] <= w_acc_wd;
        end
        if (w_acc_re) begin
            r_acc_rd <= r_acc[w_acc_ra];
        end
    end

    // out-of-range column still clears on a first element, adds nothing
    assign w_prod = r_col_ok ? 32'(r_mat_rd) * r_qval : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.sw_issue;
            r_v2 <= r_v1;
            if (i_cmd.q_start) begin
                r_idx <= '0;
            end else if (i_cmd.clr_we || i_cmd.sw_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.rd_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_qval   <= i_query_value;
            r_first  <= i_first_element;
            r_col_ok <= w_col_ok;
            r_mbase  <= w_col_ok ? MAT_AW'(i_col_sel) : '0;
        end else if (i_cmd.sw_issue) begin
            r_mbase <= r_mbase + MAT_AW'(COLS);
        end
        r_wa1     <= r_idx;
        r_wa2     <= r_wa1;
        r_prod    <= w_prod;
        r_acc_old <= r_acc_rd;
        if (i_cmd.rd_issue) begin
            r_rd_ok <= w_shard_ok && w_row_ok;
        end
        if (i_cmd.rd_load) begin
            r_out_word <= r_rd_ok ? r_acc_rd : 32'd0;
        end
    end

    assign o_stat.idx_last  = r_idx == ACC_AW'(ACC_N - 1);
    assign o_stat.pipe_busy = r_v1 || r_v2;
    assign o_stat.out_full  = r_out_valid;

    assign o_valid        = r_out_valid;
    assign o_product_word = r_out_word;

endmodule

[sv/sharded_matrix_vector_product_unit.sv]
// Sharded matrix-vector product, modulo 2^32, over SHARDS x ROWS x COLS entries.
// Write item: taken in the idle state. Read item: the accumulator word is read
// on acceptance, then loaded into the output register. Query item: a sweep over
// all SHARDS*ROWS accumulators, one multiply-accumulate per cycle through the
// single accumulator memory port pair, then a pipeline drain. After reset the
// accumulators are zeroed, one word a cycle, with no item accepted. Depends on smvp_pkg.
module sharded_matrix_vector_product_unit #(
    parameter int ROWS       = smvp_pkg::ROWS_DEF,
    parameter int COLS       = smvp_pkg::COLS_DEF,
    parameter int SHARDS     = smvp_pkg::SHARDS_DEF,
    parameter int PLAIN_BITS = smvp_pkg::PLAIN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_shard_sel,
    input  logic [5:0]  i_row_sel,
    input  logic [5:0]  i_col_sel,
    input  logic [7:0]  i_entry_value,
    input  logic [31:0] i_query_value,
    input  logic        i_first_element,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_product_word
);

    smvp_pkg::t_cmd  w_cmd;
    smvp_pkg::t_stat w_stat;

    smvp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    smvp_dpath #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .SHARDS     (SHARDS),
        .PLAIN_BITS (PLAIN_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_shard_sel     (i_shard_sel),
        .i_row_sel       (i_row_sel),
        .i_col_sel       (i_col_sel),
        .i_entry_value   (i_entry_value),
        .i_query_value   (i_query_value),
        .i_first_element (i_first_element),
        .i_stall         (i_stall),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_product_word  (o_product_word)
    );

endmodule

[test/testbench.sv]
// testbench: drives write, query and read transactions into the sharded matrix-vector
// product unit and checks every read result against its own predictor or a fixed expected value.
// Depends on smvp_pkg and sharded_matrix_vector_product_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  shard;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [7:0]  entry;
        logic [31:0] qval;
        logic        first;
    } t_mv_item;

    typedef struct packed {
        t_mv_item    item;
        logic        known;
        logic [31:0] want;
    } t_dir_row;

    localparam int N_DIRECTED = 23;
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{'{smvp_pkg::KIND_READ,  2'd0, 6'd0,  6'd0,  8'd0,   32'h0,        1'b0}, 1'b1,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd3, 6'd63, 6'd63, 8'd255, 32'hFFFFFFFF, 1'b1}, 1'b1,
          32'h0},
        '{'{KIND_UNUSED,          2'd3, 6'd63, 6'd63, 8'd255, 32'hFFFFFFFF, 1'b1}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_WRITE, 2'd3, 6'd63, 6'd63, 8'd255, 32'h0,        1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_WRITE, 2'd0, 6'd0,  6'd0,  8'd0,   32'hFFFFFFFF, 1'b1}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_WRITE, 2'd3, 6'd0,  6'd0,  8'd255, 32'h0,        1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_QUERY, 2'd0, 6'd0,  6'd0,  8'd0,   32'hFFFFFFFF, 1'b1}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd0, 6'd0,  6'd0,  8'd0,   32'h0,        1'b0}, 1'b1,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd3, 6'd0,  6'd0,  8'd0,   32'h0,        1'b0}, 1'b1,
          32'hFFFFFF01},
        '{'{smvp_pkg::KIND_QUERY, 2'd0, 6'd0,  6'd63, 8'd0,   32'hFFFFFFFF, 1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd3, 6'd63, 6'd0,  8'd0,   32'h0,        1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_QUERY, 2'd0, 6'd0,  6'd0,  8'd0,   32'h0,        1'b1}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd3, 6'd0,  6'd0,  8'd0,   32'h0,        1'b0}, 1'b1,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd2, 6'd31, 6'd0,  8'd0,   32'h0,        1'b0}, 1'b1,
          32'h0},
        '{'{smvp_pkg::KIND_QUERY, 2'd0, 6'd0,  6'd63, 8'd0,   32'h1,        1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd3, 6'd63, 6'd0,  8'd0,   32'h0,        1'b0}, 1'b1,
          32'h000000FF},
        '{'{smvp_pkg::KIND_QUERY, 2'd0, 6'd0,  6'd63, 8'd0,   32'h80000000, 1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd3, 6'd63, 6'd0,  8'd0,   32'h0,        1'b0}, 1'b1,
          32'h800000FF},
        '{'{smvp_pkg::KIND_WRITE, 2'd1, 6'd42, 6'd21, 8'hAA,  32'h0,        1'b0}, 1'b0,
          32'h0},
        '{'{KIND_UNUSED,          2'd0, 6'd0,  6'd0,  8'd0,   32'h0,        1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_QUERY, 2'd0, 6'd0,  6'd0,  8'd0,   32'h12345678, 1'b1}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd0, 6'd63, 6'd0,  8'd0,   32'h0,        1'b0}, 1'b0,
          32'h0},
        '{'{smvp_pkg::KIND_READ,  2'd1, 6'd42, 6'd0,  8'd0,   32'h0,        1'b0}, 1'b0,
          32'h0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [1:0]  i_shard_sel;
    logic [5:0]  i_row_sel;
    logic [5:0]  i_col_sel;
    logic [7:0]  i_entry_value;
    logic [31:0] i_query_value;
    logic        i_first_element;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_product_word;

    // predictor state
    logic [7:0]  entry_mem [smvp_pkg::SHARDS_DEF][smvp_pkg::ROWS_DEF][smvp_pkg::COLS_DEF];
    logic [31:0] acc_mem [smvp_pkg::SHARDS_DEF][smvp_pkg::ROWS_DEF];
    bit          col_full [smvp_pkg::COLS_DEF];
    int          full_cols [$];

    logic [31:0] product_q [$];
    int          mismatch_cnt = 0;
    int          items_sent = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_left = 0;

    sharded_matrix_vector_product_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_shard_sel    (i_shard_sel),
        .i_row_sel      (i_row_sel),
        .i_col_sel      (i_col_sel),
        .i_entry_value  (i_entry_value),
        .i_query_value  (i_query_value),
        .i_first_element(i_first_element),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_product_word (o_product_word)
    );

    always #4 i_clk = ~i_clk;

    function automatic void predict_product(input t_mv_item it, output bit has_word,
                                            output logic [31:0] word);
        has_word = 1'b0;
        word = '0;
        unique case (it.kind)
            smvp_pkg::KIND_WRITE: begin
                entry_mem[it.shard][it.row][it.col] = it.entry;
            end
            smvp_pkg::KIND_QUERY: begin
                for (int s = 0; s < smvp_pkg::SHARDS_DEF; s++) begin
                    for (int r = 0; r < smvp_pkg::ROWS_DEF; r++) begin
                        if (it.first)
                            acc_mem[s][r] = '0;
                        acc_mem[s][r] = acc_mem[s][r] + entry_mem[s][r][it.col] * it.qval;
                    end
                end
            end
            smvp_pkg::KIND_READ: begin
                has_word = 1'b1;
                word = acc_mem[it.shard][it.row];
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t ns: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // offer one transaction, wait for it to be taken, then update the predictor
    task automatic push_item(input t_mv_item it, input bit fixed, input logic [31:0] fixed_word);
        bit          has_word;
        logic [31:0] word;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_valid         <= 1'b1;
        i_kind          <= it.kind;
        i_shard_sel     <= it.shard;
        i_row_sel       <= it.row;
        i_col_sel       <= it.col;
        i_entry_value   <= it.entry;
        i_query_value   <= it.qval;
        i_first_element <= it.first;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        predict_product(it, has_word, word);
        if (has_word)
            product_q = {product_q, (fixed ? fixed_word : word)};
    endtask

    function automatic t_mv_item random_item(input logic [1:0] kind);
        t_mv_item it;
        it.kind  = kind;
        it.shard = 2'($urandom_range(3));
        it.row   = 6'($urandom_range(63));
        it.col   = 6'($urandom_range(63));
        it.entry = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                            : 8'($urandom_range(255));
        case ($urandom_range(7))
            0: it.qval = 32'h0;
            1: it.qval = 32'hFFFFFFFF;
            2: it.qval = 32'h80000000;
            default: it.qval = $urandom;
        endcase
        it.first = 1'($urandom_range(1));
        return it;
    endfunction

    // a query touches every shard and row of its column, so the whole column goes in first
    task automatic fill_column(input int c);
        t_mv_item it;
        for (int s = 0; s < smvp_pkg::SHARDS_DEF; s++) begin
            for (int r = 0; r < smvp_pkg::ROWS_DEF; r++) begin
                it = random_item(smvp_pkg::KIND_WRITE);
                it.shard = 2'(s);
                it.row   = 6'(r);
                it.col   = 6'(c);
                push_item(it, 1'b0, '0);
            end
        end
        col_full[c] = 1'b1;
        full_cols = {full_cols, c};
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (product_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: check each result, stall at random or on a long hold
    initial begin
        logic [31:0] want;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (product_q.size() == 0) begin
                    note_mismatch("result with nothing expected", 'x, o_product_word);
                end else begin
                    want = product_q.pop_front();
                    if (o_product_word !== want)
                        note_mismatch("product_word", want, o_product_word);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    initial begin
        t_mv_item it;
        int       rand_base;
        int       phase;
        int       cur_phase;
        int       op;
        int       c;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_kind          <= KIND_UNUSED;
        i_shard_sel     <= '0;
        i_row_sel       <= '0;
        i_col_sel       <= '0;
        i_entry_value   <= '0;
        i_query_value   <= '0;
        i_first_element <= 1'b0;
        foreach (acc_mem[s, r])
            acc_mem[s][r] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fill_column(0);
        fill_column(smvp_pkg::COLS_DEF - 1);

        for (int k = 0; k < N_DIRECTED; k++)
            push_item(DIRECTED[k].item, DIRECTED[k].known, DIRECTED[k].want);

        rand_base = items_sent;
        cur_phase = -1;
        while (items_sent < ITEM_TARGET) begin
            phase = (items_sent - rand_base) * 4 / (ITEM_TARGET - rand_base);
            if (phase != cur_phase) begin
                cur_phase = phase;
                if (phase != 0) begin
                    // hold the output off while reads keep coming, then let it all drain
                    src_idle_pct = 0;
                    hold_left = HOLD_CYCLES;
                    repeat (8) push_item(random_item(smvp_pkg::KIND_READ), 1'b0, '0);
                    wait_for_results();
                end
                src_idle_pct   = (phase == 1) ? 69 : (phase == 3) ? 9 : 0;
                sink_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 9 : 0;
            end
            op = $urandom_range(99);
            if (op < 2 && full_cols.size() < 4) begin
                do c = $urandom_range(smvp_pkg::COLS_DEF - 1); while (col_full[c]);
                fill_column(c);
            end else if (op < 50) begin
                push_item(random_item(smvp_pkg::KIND_WRITE), 1'b0, '0);
            end else if (op < 65) begin
                it = random_item(smvp_pkg::KIND_QUERY);
                it.col = 6'(full_cols[$urandom_range(full_cols.size() - 1)]);
                it.first = ($urandom_range(3) == 0);
                push_item(it, 1'b0, '0);
            end else if (op < 95) begin
                push_item(random_item(smvp_pkg::KIND_READ), 1'b0, '0);
            end else begin
                push_item(random_item(KIND_UNUSED), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && product_q.size() == 0)
            $display("sharded_matrix_vector_product_unit: match");
        else
            $display("sharded_matrix_vector_product_unit: mismatch");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("sharded_matrix_vector_product_unit: mismatch");
        $finish;
    end

endmodule

[sharded_matrix_vector_product_unit.f]
sv/smvp_pkg.sv
sv/smvp_ctrl.sv
sv/smvp_dpath.sv
sv/sharded_matrix_vector_product_unit.sv
test/testbench.sv
